[sv/nbd_pkg.sv]
// Shared types and codes for the session request name decoder.
// No dependencies; imported by every module of the block.
package nbd_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	// Work codes passed from the front part to the back part
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_CHAR = 2'd1;
	localparam logic [1:0] OP_ESC  = 2'd2;
	localparam logic [1:0] OP_DOT  = 2'd3;

	localparam logic [7:0] CH_LT  = 8'h3C;
	localparam logic [7:0] CH_GT  = 8'h3E;
	localparam logic [7:0] CH_DOT = 8'h2E;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} req_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       in_caller;
		logic       end_marker;
		logic       truncated;
	} res_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] value;
		logic       section;
		logic       eom;
		logic       trunc;
	} cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return 8'h30 + {4'h0, n};
		else
			return 8'h37 + {4'h0, n};
	endfunction

endpackage

[sv/nbd_front.sv]
// Front part: takes payload bytes, tracks the name/label parse state and
// turns each byte into at most one work command. Depends on nbd_pkg.
module nbd_front
	import nbd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  req_t request,
	output logic cmd_push,
	output cmd_t cmd
);

	localparam logic [2:0] PH_NAMELEN = 3'd0;
	localparam logic [2:0] PH_FIRST   = 3'd1;
	localparam logic [2:0] PH_SECOND  = 3'd2;
	localparam logic [2:0] PH_LABLEN  = 3'd3;
	localparam logic [2:0] PH_LABEL   = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;

	logic [2:0] phase_q, phase_n;
	logic       sec_q, sec_n;
	logic [3:0] hi_q, hi_n;
	logic [7:0] rem_q, rem_n;
	logic       fin_q, fin_n;
	logic [1:0] op;
	logic [7:0] value;
	logic [7:0] b;
	logic [7:0] pair;

	function automatic logic [3:0] letter_nibble(input logic [7:0] c);
		logic [7:0] d;
		d = c - 8'h41;
		if (c < 8'h41 || c > 8'h50)
			return 4'h0;
		else
			return d[3:0];
	endfunction

	function automatic logic printable(input logic [7:0] v);
		return (v >= 8'h21) && (v <= 8'h7E);
	endfunction

	assign b    = request.data_byte;
	assign pair = {hi_q, letter_nibble(b)};

	always_comb begin
		phase_n = phase_q;
		sec_n   = sec_q;
		hi_n    = hi_q;
		rem_n   = rem_q;
		fin_n   = fin_q;
		op      = OP_NONE;
		value   = b;
		unique case (phase_q)
			PH_NAMELEN: begin
				rem_n   = b;
				phase_n = (b >= 8'd2) ? PH_FIRST : PH_LABLEN;
			end
			PH_FIRST: begin
				hi_n    = letter_nibble(b);
				phase_n = PH_SECOND;
			end
			PH_SECOND: begin
				value = pair;
				// a space survives unless it is the last pair of the name
				if (printable(pair) || (pair == 8'h20 && rem_q > 8'd2))
					op = OP_CHAR;
				else
					op = OP_ESC;
				rem_n   = rem_q - 8'd2;
				phase_n = (rem_n >= 8'd2) ? PH_FIRST : PH_LABLEN;
			end
			PH_LABLEN: begin
				if (b == 8'd0) begin
					if (!sec_q) begin
						sec_n   = 1'b1;
						phase_n = PH_NAMELEN;
					end else begin
						fin_n   = 1'b1;
						phase_n = PH_DONE;
					end
				end else begin
					op      = OP_DOT;
					rem_n   = b;
					phase_n = PH_LABEL;
				end
			end
			PH_LABEL: begin
				op    = printable(b) ? OP_CHAR : OP_ESC;
				rem_n = rem_q - 8'd1;
				if (rem_n == 8'd0)
					phase_n = PH_LABLEN;
			end
			default: begin
			end
		endcase
	end

	assign cmd.op      = op;
	assign cmd.value   = value;
	assign cmd.section = sec_n;
	assign cmd.eom     = request.end_of_message;
	assign cmd.trunc   = !fin_n;
	assign cmd_push    = accept && (op != OP_NONE || request.end_of_message);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NAMELEN;
			sec_q   <= 1'b0;
			hi_q    <= 4'h0;
			rem_q   <= 8'd0;
			fin_q   <= 1'b0;
		end else if (accept) begin
			if (request.end_of_message) begin
				phase_q <= PH_NAMELEN;
				sec_q   <= 1'b0;
				hi_q    <= 4'h0;
				rem_q   <= 8'd0;
				fin_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				sec_q   <= sec_n;
				hi_q    <= hi_n;
				rem_q   <= rem_n;
				fin_q   <= fin_n;
			end
		end
	end

	a_fin_caller: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> sec_q)
		else $error("scope finished outside caller section");
	a_done_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) == fin_q)
		else $error("done phase and finished flag disagree");
	a_label_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LABEL) |-> (rem_q != 8'd0))
		else $error("label phase with nothing remaining");

endmodule

[sv/nbd_fifo.sv]
// Short command queue between the front and back parts.
// Depends on nbd_pkg for the command type.
module nbd_fifo
	import nbd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	input  logic rd,
	output cmd_t rdata,
	output logic nonempty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign nonempty = cnt_q != '0;
	assign full     = cnt_q == CNT_W'(DEPTH);
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
			if (rd)
				rp_q <= (rp_q == LAST) ? '0 : rp_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[sv/nbd_back.sv]
// Back part: expands each command into output register results, one
// per cycle unless the output is held. Depends on nbd_pkg.
module nbd_back
	import nbd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_avail,
	input  cmd_t cmd_in,
	output logic cmd_pop,
	input  logic pop,
	output logic empty,
	output res_t result
);

	cmd_t       cmd_q;
	logic       busy_q;
	logic [2:0] step_q;
	logic       ovalid_q;
	res_t       out_q;
	logic [2:0] base;
	logic [2:0] cnt;
	logic       adv;
	logic       last;
	res_t       res;

	always_comb begin
		unique case (cmd_q.op)
			OP_CHAR: base = 3'd1;
			OP_DOT:  base = 3'd1;
			OP_ESC:  base = 3'd4;
			default: base = 3'd0;
		endcase
	end

	assign cnt  = base + {2'b00, cmd_q.eom};
	assign adv  = !ovalid_q || pop;
	assign last = busy_q && (step_q == cnt - 3'd1);

	always_comb begin
		res.in_caller  = cmd_q.section;
		res.end_marker = 1'b0;
		res.truncated  = 1'b0;
		res.char_out   = cmd_q.value;
		if (step_q >= base) begin
			res.char_out   = 8'h00;
			res.end_marker = 1'b1;
			res.truncated  = cmd_q.trunc;
		end else if (cmd_q.op == OP_DOT) begin
			res.char_out = CH_DOT;
		end else if (cmd_q.op == OP_ESC) begin
			unique case (step_q[1:0])
				2'd0: res.char_out = CH_LT;
				2'd1: res.char_out = hex_char(cmd_q.value[7:4]);
				2'd2: res.char_out = hex_char(cmd_q.value[3:0]);
				default: res.char_out = CH_GT;
			endcase
		end
	end

	assign cmd_pop = cmd_avail && (!busy_q || (adv && last));
	assign empty   = !ovalid_q;
	assign result  = out_q;

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cmd_q <= cmd_in;
		if (adv && busy_q)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= 3'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (adv)
				ovalid_q <= busy_q;
			if (cmd_pop) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (adv && busy_q) begin
				if (last)
					busy_q <= 1'b0;
				else
					step_q <= step_q + 3'd1;
			end
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q < cnt))
		else $error("expansion step past command length");
	a_marker_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && !out_q.end_marker) |-> !out_q.truncated)
		else $error("truncated flag on a character result");
	a_marker_char: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && out_q.end_marker) |-> (out_q.char_out == 8'h00))
		else $error("end marker with nonzero character");

endmodule

[sv/netbios_name_decoder.sv]
// Top level of the session request name decoder: front parser, command
// queue and result expander. Depends on nbd_pkg, nbd_front, nbd_fifo, nbd_back.

// The decoder takes one payload byte per transfer and returns the decoded
// called and caller names as a stream of characters, ending each message
// with one end marker result. A byte is taken whenever the command queue
// has room; the back part then gives one result per cycle unless its
// output is held, so a byte yields 0 to 5 results (one for a plain character
// or label dot, four for an escape, plus one for the end marker); the sustained
// rate is set by that expander and the pop rate. The queue of QUEUE_DEPTH
// commands lets bytes that give no result pass while escapes drain.
module netbios_name_decoder
	import nbd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t request,
	output logic empty,
	input  logic pop,
	output res_t result
);

	logic accept;
	logic cmd_push;
	cmd_t cmd_w;
	cmd_t cmd_r;
	logic cmd_avail;
	logic cmd_pop;

	assign accept = push && !full;

	nbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.request  (request),
		.cmd_push (cmd_push),
		.cmd      (cmd_w)
	);

	nbd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (cmd_push),
		.wdata    (cmd_w),
		.rd       (cmd_pop),
		.rdata    (cmd_r),
		.nonempty (cmd_avail),
		.full     (full)
	);

	nbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (cmd_avail),
		.cmd_in    (cmd_r),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

[bench/nbd_checker.sv]
// Scoreboard for the session request name decoder: watches both queue ports,
// predicts the decoded character stream and compares it in order.
// Depends on nbd_pkg for the request and result types and character codes.
module nbd_checker
	import nbd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  req_t request,
	input  logic empty,
	input  logic pop,
	input  res_t result,
	output int   errors,
	output int   pending
);

	typedef enum logic [2:0] {
		ST_NAMELEN,
		ST_FIRST,
		ST_SECOND,
		ST_LABLEN,
		ST_LABEL,
		ST_DONE
	} dec_phase_t;

	localparam logic [7:0] ASCII_A     = 8'h41;
	localparam logic [7:0] ASCII_P     = 8'h50;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_BANG  = 8'h21;
	localparam logic [7:0] ASCII_TILDE = 8'h7E;
	localparam logic [7:0] HEX_DIGITS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	dec_phase_t cur_phase;
	logic       caller_sec;
	logic [3:0] hi_nib;
	logic [7:0] bytes_left;
	logic       scope_done;
	res_t       decoded_q[$];

	function automatic logic [3:0] letter_value(input logic [7:0] c);
		if (c < ASCII_A || c > ASCII_P)
			return 4'h0;
		return 4'(c - ASCII_A);
	endfunction

	task automatic add_char(input logic [7:0] c, input logic endm, input logic trunc);
		res_t r;
		r.char_out   = c;
		r.in_caller  = caller_sec;
		r.end_marker = endm;
		r.truncated  = trunc;
		decoded_q.push_back(r);
	endtask

	// printable bytes, and a space where allowed, pass as is; everything else becomes <HH>
	task automatic add_escaped(input logic [7:0] v, input logic space_ok);
		if ((v >= ASCII_BANG && v <= ASCII_TILDE) ||
			(v == ASCII_SPACE && space_ok)) begin
			add_char(v, 1'b0, 1'b0);
		end else begin
			add_char(CH_LT, 1'b0, 1'b0);
			add_char(HEX_DIGITS[v[7:4]], 1'b0, 1'b0);
			add_char(HEX_DIGITS[v[3:0]], 1'b0, 1'b0);
			add_char(CH_GT, 1'b0, 1'b0);
		end
	endtask

	task automatic clear_decoder();
		cur_phase  = ST_NAMELEN;
		caller_sec = 1'b0;
		hi_nib     = 4'h0;
		bytes_left = 8'h00;
		scope_done = 1'b0;
	endtask

	task automatic decode_byte(input req_t rq);
		logic [7:0] b;
		b = rq.data_byte;
		case (cur_phase)
			ST_NAMELEN: begin
				bytes_left = b;
				cur_phase  = (b >= 8'd2) ? ST_FIRST : ST_LABLEN;
			end
			ST_FIRST: begin
				hi_nib    = letter_value(b);
				cur_phase = ST_SECOND;
			end
			ST_SECOND: begin
				// a space in the last pair is padding and gets escaped
				add_escaped({hi_nib, letter_value(b)}, bytes_left > 8'd2);
				bytes_left = bytes_left - 8'd2;
				cur_phase  = (bytes_left >= 8'd2) ? ST_FIRST : ST_LABLEN;
			end
			ST_LABLEN: begin
				if (b == 8'h00) begin
					if (!caller_sec) begin
						caller_sec = 1'b1;
						cur_phase  = ST_NAMELEN;
					end else begin
						scope_done = 1'b1;
						cur_phase  = ST_DONE;
					end
				end else begin
					add_char(CH_DOT, 1'b0, 1'b0);
					bytes_left = b;
					cur_phase  = ST_LABEL;
				end
			end
			ST_LABEL: begin
				add_escaped(b, 1'b0);
				bytes_left = bytes_left - 8'd1;
				if (bytes_left == 8'h00)
					cur_phase = ST_LABLEN;
			end
			default: ;
		endcase
		if (rq.end_of_message) begin
			add_char(8'h00, 1'b1, !scope_done);
			clear_decoder();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			clear_decoder();
			decoded_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (push && !full)
				decode_byte(request);
			if (pop && !empty) begin
				got = result;
				if (decoded_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result char=%h caller=%b end=%b trunc=%b",
							$realtime, got.char_out, got.in_caller, got.end_marker,
							got.truncated);
				end else begin
					want = decoded_q.pop_front();
					if (got.char_out !== want.char_out ||
						got.in_caller !== want.in_caller ||
						got.end_marker !== want.end_marker ||
						got.truncated !== want.truncated) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: result mismatch expected char=%h caller=%b ",
								"end=%b trunc=%b, got char=%h caller=%b end=%b trunc=%b"},
								$realtime, want.char_out, want.in_caller, want.end_marker,
								want.truncated, got.char_out, got.in_caller,
								got.end_marker, got.truncated);
					end
				end
			end
			pending = decoded_q.size();
		end
	end

endmodule

[bench/testbench.sv]
// Top of the name decoder bench: clock, reset, byte stimulus and result popping.
// Depends on nbd_pkg, netbios_name_decoder and nbd_checker.
module testbench;
	import nbd_pkg::*;

	localparam int TARGET_BYTES = 470;
	localparam int HOLD_CYCLES  = 100;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	req_t request;
	logic empty;
	logic pop;
	res_t result;
	int   errors;
	int   pending;

	int   bytes_sent;
	bit   hold_req;
	bit   hold_issued;
	bit   drain_issued;
	req_t msg_q[$];
	wire  quiet = (bytes_sent >= 200) && (bytes_sent < 300);

	netbios_name_decoder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	nbd_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result side: random pop gaps, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				pop <= 1'b0;
			end else begin
				pop <= quiet || ($urandom_range(0, 99) >= 11);
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic put_byte(input logic [7:0] b, input logic eom);
		while (!quiet && $urandom_range(0, 99) < 11) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		request <= '{data_byte: b, end_of_message: eom};
		do
			@(posedge clk);
		while (full);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	task automatic add_byte(input logic [7:0] b);
		msg_q.push_back('{data_byte: b, end_of_message: 1'b0});
	endtask

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'h41 + 8'($urandom_range(0, 15));
	endfunction

	// length byte, letter pairs, up to two scope labels, zero terminator
	task automatic add_name();
		int r;
		int len;
		int nlab;
		int llen;
		r = $urandom_range(0, 99);
		if (r < 15)
			len = 32;
		else if (r < 30)
			len = $urandom_range(0, 9);
		else
			len = 2 * $urandom_range(0, 6);
		add_byte(8'(len));
		for (int i = 0; i < (len / 2) * 2; i++)
			add_byte(rand_letter());
		nlab = $urandom_range(0, 2);
		for (int k = 0; k < nlab; k++) begin
			llen = $urandom_range(1, 5);
			add_byte(8'(llen));
			for (int j = 0; j < llen; j++)
				add_byte(8'($urandom_range(0, 255)));
		end
		add_byte(8'h00);
	endtask

	task automatic send_msg();
		msg_q[msg_q.size() - 1].end_of_message = 1'b1;
		foreach (msg_q[i])
			put_byte(msg_q[i].data_byte, msg_q[i].end_of_message);
		msg_q.delete();
	endtask

	initial begin
		int r;
		int cut;
		arst_n = 1'b0;
		push = 1'b0;
		request = '0;
		bytes_sent = 0;
		hold_req = 1'b0;
		hold_issued = 1'b0;
		drain_issued = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// spaces inside and at the end of a name, clamped letters, escaped
		// label bytes, odd caller length, trailing bytes after the caller scope
		put_byte(8'h06, 1'b0);
		put_byte("C", 1'b0);
		put_byte("A", 1'b0);
		put_byte("E", 1'b0);
		put_byte("B", 1'b0);
		put_byte("C", 1'b0);
		put_byte("A", 1'b0);
		put_byte(8'h02, 1'b0);
		put_byte(8'h20, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h05, 1'b0);
		put_byte("Z", 1'b0);
		put_byte("P", 1'b0);
		put_byte("H", 1'b0);
		put_byte("H", 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h7E, 1'b0);
		put_byte(8'h41, 1'b1);
		// empty called name, message ends on an escaped label byte
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h03, 1'b0);
		put_byte("P", 1'b0);
		put_byte("P", 1'b0);
		put_byte(8'h01, 1'b0);
		put_byte(8'h00, 1'b1);
		// message ends inside a pair
		put_byte(8'h04, 1'b0);
		put_byte("A", 1'b1);
		drain_results();

		while (bytes_sent < TARGET_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				// noise
				repeat ($urandom_range(1, 8))
					add_byte(8'($urandom_range(0, 255)));
			end else begin
				add_name();
				add_name();
				repeat ($urandom_range(0, 2))
					add_byte(8'($urandom_range(0, 255)));
				if (r < 30) begin
					cut = $urandom_range(0, msg_q.size() - 1);
					msg_q = msg_q[0:cut];
				end
			end
			if (bytes_sent >= 150 && !hold_issued) begin
				hold_issued = 1'b1;
				hold_req = 1'b1;
			end
			if (bytes_sent >= 320 && !drain_issued) begin
				drain_issued = 1'b1;
				drain_results();
			end
			send_msg();
		end

		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
